### rtl/core/btm_pkg.sv
// ---------------------------------------------------------------------------
// btm_pkg: shared types and constants for the breath/touch MIDI encoder
// Field widths, calibration store geometry, MIDI codes and the note table.
// ---------------------------------------------------------------------------
`default_nettype none

package btm_pkg;

    localparam int NUM_KEYS    = 6;
    localparam int TIME_W      = 16;
    localparam int BREATH_W    = 8;
    localparam int VOL_W       = 7;
    localparam int CAL_SAMPLES = 11;
    localparam int CAL_AW      = $clog2(CAL_SAMPLES);
    localparam int ROW_W       = NUM_KEYS * TIME_W;

    localparam logic [CAL_AW-1:0] MED_IDX  = CAL_AW'(CAL_SAMPLES / 2);
    localparam logic [CAL_AW-1:0] LAST_IDX = CAL_AW'(CAL_SAMPLES - 1);

    // volume = blow * 127 / 47 as a reciprocal multiply, exact for blow < 47
    localparam logic [BREATH_W-1:0] BREATH_FULL = 8'h2F;
    localparam logic [VOL_W-1:0]    VOL_MAX     = 7'd127;
    localparam int                  VOL_MUL_W   = 20;
    localparam logic [VOL_MUL_W-1:0] VOL_MUL    = 20'd708406;
    localparam int                  VOL_SHIFT   = 18;
    localparam int                  VOL_PROD_W  = 26;

    // config register indexes
    localparam logic CFG_MEDIAN_OFFSET = 1'b0;
    localparam logic CFG_SILENCE_LEVEL = 1'b1;

    // MIDI codes
    localparam logic [7:0] MIDI_CC       = 8'hB0;
    localparam logic [7:0] MIDI_NOTE_ON  = 8'h90;
    localparam logic [7:0] MIDI_ALL_OFF  = 8'h7B;
    localparam logic [7:0] MIDI_VOLUME   = 8'h07;
    localparam logic [7:0] MIDI_BEND     = 8'hE0;
    localparam logic [7:0] MIDI_ZERO     = 8'h00;

    // byte run positions: all-off 0..2, note-on 3..5, volume 6..8, bend 9..11
    localparam logic [3:0] RUN_FIRST  = 4'd0;
    localparam logic [3:0] RUN_VOLUME = 4'd6;
    localparam logic [3:0] RUN_OFF_END = 4'd2;
    localparam logic [3:0] RUN_END    = 4'd11;

    localparam logic [VOL_W-1:0] NOTE_OTHER = 7'd27;

    typedef logic [NUM_KEYS-1:0][TIME_W-1:0] t_times;

    typedef struct packed {
        t_times              thr;
        logic [BREATH_W-1:0] base;
        logic                busy;
    } t_cal_out;

    function automatic logic [VOL_W-1:0] note_for_mask(input logic [NUM_KEYS-1:0] mask);
        logic [VOL_W-1:0] note;
        case (mask)
            6'h3F:   note = 7'd62;
            6'h3E:   note = 7'd64;
            6'h3C:   note = 7'd66;
            6'h38:   note = 7'd67;
            6'h30:   note = 7'd69;
            6'h20:   note = 7'd71;
            6'h00:   note = 7'd73;
            6'h1F:   note = 7'd74;
            default: note = NOTE_OTHER;
        endcase
        return note;
    endfunction

endpackage

`default_nettype wire

### rtl/core/btm_cal.sv
// ---------------------------------------------------------------------------
// btm_cal: calibration store and threshold unit
// Rows of the sorted store hold one entry of all six channels. An insertion
// walks down from the run's fill index, one read and one write per row, a write alone at row 0.
// ---------------------------------------------------------------------------
`default_nettype none

module btm_cal (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    input  wire btm_pkg::t_times                   i_times,
    input  wire logic [btm_pkg::BREATH_W-1:0]      i_breath,
    input  wire logic [btm_pkg::TIME_W-1:0]        i_median_offset,
    output btm_pkg::t_cal_out                      o_cal
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_WR,
        S_MRD,
        S_MWR
    } t_state;

    t_state                              r_state;
    logic [btm_pkg::CAL_AW-1:0]          r_count;
    logic [btm_pkg::CAL_AW-1:0]          r_k;
    btm_pkg::t_times                     r_v;
    btm_pkg::t_times                     r_above;
    btm_pkg::t_times                     r_thr;
    logic [btm_pkg::NUM_KEYS-1:0]        r_done;
    logic [btm_pkg::BREATH_W-1:0]        r_breath;
    logic [btm_pkg::BREATH_W-1:0]        r_base;

    logic [btm_pkg::ROW_W-1:0]           r_mem [btm_pkg::CAL_SAMPLES];
    logic [btm_pkg::ROW_W-1:0]           r_rd_data;

    btm_pkg::t_times                     w_rd_row;
    btm_pkg::t_times                     n_row;
    logic [btm_pkg::NUM_KEYS-1:0]        n_done;
    logic                                w_rd_en;
    logic [btm_pkg::CAL_AW-1:0]          w_rd_addr;
    logic                                w_wr_en;

    assign w_rd_row  = btm_pkg::t_times'(r_rd_data);
    assign w_rd_en   = (r_state == S_RD) || (r_state == S_MRD);
    assign w_rd_addr = (r_state == S_MRD) ? btm_pkg::MED_IDX : r_k - 1'b1;
    assign w_wr_en   = (r_state == S_WR);

    // new contents of row k; at row 0 every channel still open takes its value
    always_comb begin
        for (int ch = 0; ch < btm_pkg::NUM_KEYS; ch++) begin
            if (r_done[ch]) begin
                n_row[ch]  = r_above[ch];
                n_done[ch] = 1'b1;
            end else if ((r_k != '0) && (w_rd_row[ch] > r_v[ch])) begin
                n_row[ch]  = w_rd_row[ch];
                n_done[ch] = 1'b0;
            end else begin
                n_row[ch]  = r_v[ch];
                n_done[ch] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_k] <= btm_pkg::ROW_W'(n_row);
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_thr   <= '0;
            r_base  <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_v      <= i_times;
                        r_breath <= i_breath;
                        r_k      <= r_count;
                        r_done   <= '0;
                        r_state  <= (r_count == '0) ? S_WR : S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_WR;
                end
                S_WR: begin
                    r_done  <= n_done;
                    r_above <= w_rd_row;
                    if (r_k != '0) begin
                        r_k     <= r_k - 1'b1;
                        r_state <= (r_k == 1) ? S_WR : S_RD;
                    end else if (r_count == btm_pkg::LAST_IDX) begin
                        r_count <= '0;
                        r_state <= S_MRD;
                    end else begin
                        r_count <= r_count + 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_MRD: begin
                    r_state <= S_MWR;
                end
                S_MWR: begin
                    for (int ch = 0; ch < btm_pkg::NUM_KEYS; ch++) begin
                        r_thr[ch] <= w_rd_row[ch] + i_median_offset;
                    end
                    r_base  <= r_breath;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_cal.thr  = r_thr;
    assign o_cal.base = r_base;
    assign o_cal.busy = (r_state != S_IDLE);

endmodule

`default_nettype wire

### rtl/core/btm_play.sv
// ---------------------------------------------------------------------------
// btm_play: play frame unit
// Touch mask and note, breath volume, run selection and the byte emitter
// with its output register.
// ---------------------------------------------------------------------------
`default_nettype none

module btm_play (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    input  wire btm_pkg::t_times                   i_times,
    input  wire logic [btm_pkg::BREATH_W-1:0]      i_breath,
    input  wire btm_pkg::t_cal_out                 i_cal,
    input  wire logic [btm_pkg::VOL_W-1:0]         i_silence_level,
    input  wire logic                              i_stall,
    output logic                                   o_busy,
    output logic                                   o_valid,
    output logic [7:0]                             o_midi_byte,
    output logic                                   o_last
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MASK,
        S_VOL,
        S_DEC,
        S_EMIT
    } t_state;

    t_state                              r_state;
    btm_pkg::t_times                     r_times;
    logic [btm_pkg::BREATH_W-1:0]        r_breath;
    logic [btm_pkg::BREATH_W-1:0]        r_blow;
    logic [btm_pkg::VOL_W-1:0]           r_note;
    logic [btm_pkg::VOL_W-1:0]           r_vol;
    logic [btm_pkg::VOL_W-1:0]           r_cur_note;
    logic [btm_pkg::VOL_W-1:0]           r_cur_vol;
    logic [3:0]                          r_idx;
    logic [3:0]                          r_end;
    logic                                r_out_valid;
    logic [7:0]                          r_out_byte;
    logic                                r_out_last;

    logic [btm_pkg::NUM_KEYS-1:0]        w_mask;
    logic [btm_pkg::VOL_PROD_W-1:0]      w_prod;
    logic                                w_slot_free;
    logic [7:0]                          w_byte;

    always_comb begin
        for (int ch = 0; ch < btm_pkg::NUM_KEYS; ch++) begin
            w_mask[ch] = (r_times[ch] > i_cal.thr[ch]);
        end
    end

    assign w_prod = btm_pkg::VOL_PROD_W'(r_blow[5:0]) * btm_pkg::VOL_PROD_W'(btm_pkg::VOL_MUL);
    assign w_slot_free = !r_out_valid || !i_stall;

    always_comb begin
        case (r_idx)
            4'd0:    w_byte = btm_pkg::MIDI_CC;
            4'd1:    w_byte = btm_pkg::MIDI_ALL_OFF;
            4'd2:    w_byte = btm_pkg::MIDI_ZERO;
            4'd3:    w_byte = btm_pkg::MIDI_NOTE_ON;
            4'd4:    w_byte = {1'b0, r_note};
            4'd5:    w_byte = {1'b0, r_vol};
            4'd6:    w_byte = btm_pkg::MIDI_CC;
            4'd7:    w_byte = btm_pkg::MIDI_VOLUME;
            4'd8:    w_byte = {1'b0, r_vol};
            4'd9:    w_byte = btm_pkg::MIDI_BEND;
            default: w_byte = btm_pkg::MIDI_ZERO;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cur_note  <= '0;
            r_cur_vol   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_times  <= i_times;
                        r_breath <= i_breath;
                        r_state  <= S_MASK;
                    end
                end
                S_MASK: begin
                    r_note  <= btm_pkg::note_for_mask(w_mask);
                    r_blow  <= (r_breath > i_cal.base) ? r_breath - i_cal.base : '0;
                    r_state <= S_VOL;
                end
                S_VOL: begin
                    r_vol   <= (r_blow >= btm_pkg::BREATH_FULL) ? btm_pkg::VOL_MAX
                               : w_prod[btm_pkg::VOL_SHIFT +: btm_pkg::VOL_W];
                    r_state <= S_DEC;
                end
                S_DEC: begin
                    r_cur_note <= r_note;
                    r_cur_vol  <= r_vol;
                    if (r_vol <= i_silence_level) begin
                        r_idx <= btm_pkg::RUN_FIRST;
                        r_end <= btm_pkg::RUN_OFF_END;
                    end else if ((r_note != r_cur_note) || (r_cur_vol == '0)) begin
                        r_idx <= btm_pkg::RUN_FIRST;
                        r_end <= btm_pkg::RUN_END;
                    end else begin
                        r_idx <= btm_pkg::RUN_VOLUME;
                        r_end <= btm_pkg::RUN_END;
                    end
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (w_slot_free) begin
                        r_out_valid <= 1'b1;
                        r_out_byte  <= w_byte;
                        r_out_last  <= (r_idx == r_end);
                        r_idx       <= r_idx + 1'b1;
                        if (r_idx == r_end) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_valid     = r_out_valid;
    assign o_midi_byte = r_out_byte;
    assign o_last      = r_out_last;

endmodule

`default_nettype wire

### rtl/core/breath_touch_to_midi_encoder.sv
// Calibration item: stall held while the store unit walks down from row n for sample n of a
// run, n counted from 0 (one store read and one write per row passed), then while it reads the
// median row on the run's last sample. Play item: the first byte follows the mask, volume and
// decision states, then one byte per cycle while the output is not stalled; runs of 3, 6 or
// 12 bytes. The next item is taken once the run's last byte sits in the output register.
// Synchronous active-low reset clears control, thresholds, base and note state; the sorted
// store has no reset and is only read at rows already written in the current run.
// ---------------------------------------------------------------------------
// breath_touch_to_midi_encoder: breath and key touch to MIDI byte stream
// Routes calibration items to the store unit and play frames to the play unit.
// ---------------------------------------------------------------------------
`default_nettype none

module breath_touch_to_midi_encoder (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_stall,
    input  wire logic                              i_mode,
    input  wire logic [btm_pkg::TIME_W-1:0]        i_time_0,
    input  wire logic [btm_pkg::TIME_W-1:0]        i_time_1,
    input  wire logic [btm_pkg::TIME_W-1:0]        i_time_2,
    input  wire logic [btm_pkg::TIME_W-1:0]        i_time_3,
    input  wire logic [btm_pkg::TIME_W-1:0]        i_time_4,
    input  wire logic [btm_pkg::TIME_W-1:0]        i_time_5,
    input  wire logic [btm_pkg::BREATH_W-1:0]      i_breath,
    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output logic [7:0]                             o_midi_byte,
    output logic                                   o_last,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic                              i_cfg_index,
    input  wire logic [btm_pkg::TIME_W-1:0]        i_cfg_data
);

    logic [btm_pkg::TIME_W-1:0]  r_median_offset;
    logic [btm_pkg::VOL_W-1:0]   r_silence_level;

    btm_pkg::t_times             w_times;
    btm_pkg::t_cal_out           w_cal;
    logic                        w_play_busy;
    logic                        w_take;

    assign w_times = {i_time_5, i_time_4, i_time_3, i_time_2, i_time_1, i_time_0};
    assign o_stall = w_cal.busy || w_play_busy;
    assign w_take  = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_median_offset <= 16'd128;
            r_silence_level <= 7'd7;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                btm_pkg::CFG_MEDIAN_OFFSET: r_median_offset <= i_cfg_data;
                btm_pkg::CFG_SILENCE_LEVEL: r_silence_level <= i_cfg_data[btm_pkg::VOL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    btm_cal u_cal (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (w_take && !i_mode),
        .i_times         (w_times),
        .i_breath        (i_breath),
        .i_median_offset (r_median_offset),
        .o_cal           (w_cal)
    );

    btm_play u_play (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (w_take && i_mode),
        .i_times         (w_times),
        .i_breath        (i_breath),
        .i_cal           (w_cal),
        .i_silence_level (r_silence_level),
        .i_stall         (i_stall),
        .o_busy          (w_play_busy),
        .o_valid         (o_valid),
        .o_midi_byte     (o_midi_byte),
        .o_last          (o_last)
    );

endmodule

`default_nettype wire

### verif/btm_midi_checker.sv
// ---------------------------------------------------------------------------
// btm_midi_checker: scoreboard for the breath/touch MIDI encoder
// Watches the item, byte and register channels, keeps its own copy of the
// calibration stores, thresholds and note state, and compares every byte
// transfer against the predicted run, field by field.
// ---------------------------------------------------------------------------
module btm_midi_checker
    import btm_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    input  wire logic                 i_in_stall,
    input  wire logic                 i_mode,
    input  wire t_times               i_times,
    input  wire logic [BREATH_W-1:0]  i_breath,
    input  wire logic                 i_out_valid,
    input  wire logic                 i_out_stall,
    input  wire logic [7:0]           i_midi_byte,
    input  wire logic                 i_last,
    input  wire logic                 i_cfg_valid,
    input  wire logic                 i_cfg_ready,
    input  wire logic                 i_cfg_index,
    input  wire logic [TIME_W-1:0]    i_cfg_data,
    input  wire logic                 i_end,
    output int                        o_fail_count,
    output int                        o_pending,
    output int                        o_byte_count
);
    timeunit 1ns;
    timeprecision 1ps;

    // fingering masks and their notes, entry 0 in the low bits
    localparam logic [47:0] FINGERINGS   = {6'h1F, 6'h00, 6'h20, 6'h30,
                                            6'h38, 6'h3C, 6'h3E, 6'h3F};
    localparam logic [55:0] FINGER_NOTES = {7'd74, 7'd73, 7'd71, 7'd69,
                                            7'd67, 7'd66, 7'd64, 7'd62};

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_midi_beat;

    t_midi_beat          due_bytes[$];
    logic [TIME_W-1:0]   cal_rows [NUM_KEYS][CAL_SAMPLES];
    logic [3:0]          cal_fill;
    t_times              key_thr;
    logic [BREATH_W-1:0] rest_breath;
    logic [VOL_W-1:0]    prev_note;
    logic [VOL_W-1:0]    prev_vol;
    logic [TIME_W-1:0]   offset_reg;
    logic [VOL_W-1:0]    silence_reg;
    logic [7:0]          run_buf [12];
    int                  run_len;
    int                  mismatch_cnt;
    int                  byte_cnt;

    task automatic report(input string msg);
        $display("[%0t] ERROR %s", $realtime, msg);
        mismatch_cnt++;
    endtask

    function automatic void stage(input logic [7:0] d);
        run_buf[run_len] = d;
        run_len++;
    endfunction

    // insertion into the per-key sorted stores; the last sample of a run
    // sets thresholds from the median and latches the rest breath
    task automatic store_sample(input t_times t, input logic [BREATH_W-1:0] br);
        int unsigned pos;
        int unsigned k;
        pos = (cal_fill >= CAL_SAMPLES) ? 0 : cal_fill;
        for (int ch = 0; ch < NUM_KEYS; ch++) begin
            k = pos;
            while (k > 0 && cal_rows[ch][k-1] > t[ch]) begin
                cal_rows[ch][k] = cal_rows[ch][k-1];
                k--;
            end
            cal_rows[ch][k] = t[ch];
        end
        pos++;
        if (pos >= CAL_SAMPLES) begin
            for (int ch = 0; ch < NUM_KEYS; ch++) begin
                key_thr[ch] = cal_rows[ch][CAL_SAMPLES/2] + offset_reg;
            end
            rest_breath = br;
            cal_fill    = '0;
        end else begin
            cal_fill = 4'(pos);
        end
    endtask

    task automatic predict_frame(input t_times t, input logic [BREATH_W-1:0] br);
        logic [NUM_KEYS-1:0] mask;
        logic [VOL_W-1:0]    note;
        logic [VOL_W-1:0]    vol;
        logic [BREATH_W-1:0] blow;
        t_midi_beat          beat;
        mask = '0;
        for (int ch = 0; ch < NUM_KEYS; ch++) begin
            mask[ch] = (t[ch] > key_thr[ch]);
        end
        note = NOTE_OTHER;
        for (int i = 0; i < 8; i++) begin
            if (mask == FINGERINGS[i*6 +: 6]) note = FINGER_NOTES[i*7 +: 7];
        end
        blow = (br > rest_breath) ? br - rest_breath : '0;
        if (blow >= BREATH_FULL) begin
            vol = VOL_MAX;
        end else begin
            vol = VOL_W'((32'(blow) * 32'(VOL_MAX)) / 32'(BREATH_FULL));
        end

        run_len = 0;
        if (vol <= silence_reg) begin
            stage(MIDI_CC);
            stage(MIDI_ALL_OFF);
            stage(MIDI_ZERO);
        end else begin
            // retrigger on a new note or when coming out of zero volume
            if (note != prev_note || prev_vol == '0) begin
                stage(MIDI_CC);
                stage(MIDI_ALL_OFF);
                stage(MIDI_ZERO);
                stage(MIDI_NOTE_ON);
                stage({1'b0, note});
                stage({1'b0, vol});
            end
            stage(MIDI_CC);
            stage(MIDI_VOLUME);
            stage({1'b0, vol});
            stage(MIDI_BEND);
            stage(MIDI_ZERO);
            stage(MIDI_ZERO);
        end
        prev_note = note;
        prev_vol  = vol;
        for (int k = 0; k < run_len; k++) begin
            beat.data = run_buf[k];
            beat.last = (k == run_len - 1);
            due_bytes.push_back(beat);
        end
    endtask

    always @(posedge i_clk) begin
        t_midi_beat want;
        if (!i_rst_n) begin
            due_bytes.delete();
            for (int ch = 0; ch < NUM_KEYS; ch++) begin
                for (int k = 0; k < CAL_SAMPLES; k++) cal_rows[ch][k] = '0;
            end
            cal_fill    = '0;
            key_thr     = '0;
            rest_breath = '0;
            prev_note   = '0;
            prev_vol    = '0;
            offset_reg  = 16'd128;
            silence_reg = 7'd7;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                byte_cnt++;
                if (due_bytes.size() == 0) begin
                    report($sformatf("byte transfer %02h with no byte expected", i_midi_byte));
                end else begin
                    want = due_bytes.pop_front();
                    if (i_midi_byte !== want.data) begin
                        report($sformatf("byte %0d: midi_byte %02h, expected %02h",
                                         byte_cnt, i_midi_byte, want.data));
                    end
                    if (i_last !== want.last) begin
                        report($sformatf("byte %0d: last %b, expected %b",
                                         byte_cnt, i_last, want.last));
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_mode) predict_frame(i_times, i_breath);
                else        store_sample(i_times, i_breath);
            end
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_MEDIAN_OFFSET) offset_reg  = i_cfg_data;
                else                                  silence_reg = i_cfg_data[VOL_W-1:0];
            end
            if (i_end && due_bytes.size() != 0) begin
                report($sformatf("%0d expected bytes never arrived", due_bytes.size()));
            end
        end
        o_pending    <= due_bytes.size();
        o_fail_count <= mismatch_cnt;
        o_byte_count <= byte_cnt;
    end

endmodule

### verif/tb_breath_touch_to_midi_encoder.sv
// ---------------------------------------------------------------------------
// tb_breath_touch_to_midi_encoder: testbench for the breath/touch MIDI encoder
// Drives calibration runs (planned medians or noise) and play frames aimed at each
// fingering, under bursty input and a changing output stall pattern, across
// several register settings; the checker scores every byte.
// ---------------------------------------------------------------------------
module tb_breath_touch_to_midi_encoder
    import btm_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAME_SETTLE = 40;
    localparam logic [47:0] FINGERINGS = {6'h1F, 6'h00, 6'h20, 6'h30,
                                          6'h38, 6'h3C, 6'h3E, 6'h3F};

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_valid     = 1'b0;
    logic                o_stall;
    logic                i_mode      = 1'b0;
    logic [TIME_W-1:0]   i_time_0    = '0;
    logic [TIME_W-1:0]   i_time_1    = '0;
    logic [TIME_W-1:0]   i_time_2    = '0;
    logic [TIME_W-1:0]   i_time_3    = '0;
    logic [TIME_W-1:0]   i_time_4    = '0;
    logic [TIME_W-1:0]   i_time_5    = '0;
    logic [BREATH_W-1:0] i_breath    = '0;
    logic                o_valid;
    logic                i_stall     = 1'b0;
    logic [7:0]          o_midi_byte;
    logic                o_last;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic                i_cfg_index = CFG_MEDIAN_OFFSET;
    logic [TIME_W-1:0]   i_cfg_data  = '0;
    logic                end_check   = 1'b0;

    int fail_count;
    int pending;
    int bytes_checked;

    // what the stimulus knows about the thresholds it planned
    t_times        thr_plan;
    logic [7:0]    base_plan;
    bit            thr_known;
    logic [5:0]    prev_mask;
    logic [15:0]   cur_offset = 16'd128;
    int            burst_left = 0;
    int            cal_items, play_items, cal_runs, settings_used;

    breath_touch_to_midi_encoder dut (
        .i_clk, .i_rst_n,
        .i_valid, .o_stall,
        .i_mode, .i_time_0, .i_time_1, .i_time_2, .i_time_3, .i_time_4, .i_time_5,
        .i_breath,
        .o_valid, .i_stall, .o_midi_byte, .o_last,
        .i_cfg_valid, .o_cfg_ready, .i_cfg_index, .i_cfg_data
    );

    btm_midi_checker u_midi_chk (
        .i_clk, .i_rst_n,
        .i_in_valid(i_valid), .i_in_stall(o_stall), .i_mode,
        .i_times({i_time_5, i_time_4, i_time_3, i_time_2, i_time_1, i_time_0}),
        .i_breath,
        .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_midi_byte(o_midi_byte), .i_last(o_last),
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data,
        .i_end(end_check),
        .o_fail_count(fail_count), .o_pending(pending), .o_byte_count(bytes_checked)
    );

    always #5 i_clk = ~i_clk;

    // output stall: switches between free, light, heavy and periodic styles
    int          stall_style = 0;
    int          stall_age   = 0;
    int unsigned tick        = 0;
    always @(posedge i_clk) begin
        if (stall_age == 0) begin
            stall_style = $urandom_range(3, 0);
            stall_age   = $urandom_range(120, 20);
        end
        stall_age--;
        tick++;
        case (stall_style)
            0:       i_stall <= 1'b0;
            1:       i_stall <= ($urandom_range(3, 0) == 0);
            2:       i_stall <= ($urandom_range(3, 0) != 0);
            default: i_stall <= (tick % 4 != 0);
        endcase
    end

    initial begin
        #5_000_000;
        $display("tb_breath_touch_to_midi_encoder failed");
        $finish;
    end

    task automatic send_item(input logic mode, input t_times t, input logic [7:0] br);
        if (burst_left == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(12, 1)) @(posedge i_clk);
            burst_left = ($urandom_range(5, 0) == 0) ? 40 : $urandom_range(12, 1);
        end
        burst_left--;
        i_valid  <= 1'b1;
        i_mode   <= mode;
        i_time_0 <= t[0];
        i_time_1 <= t[1];
        i_time_2 <= t[2];
        i_time_3 <= t[3];
        i_time_4 <= t[4];
        i_time_5 <= t[5];
        i_breath <= br;
        @(posedge i_clk);
        while (o_stall !== 1'b0) @(posedge i_clk);
        if (mode) play_items++;
        else      cal_items++;
    endtask

    // hold off until every expected byte is out and any calibration finished
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (FRAME_SETTLE) @(posedge i_clk);
    endtask

    // valid stays up on return; the caller drops it after its last write
    task automatic cfg_write(input logic idx, input logic [15:0] d);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        @(posedge i_clk);
        while (o_cfg_ready !== 1'b1) @(posedge i_clk);
    endtask

    task automatic new_setting(input logic [15:0] offs, input logic [6:0] quiet);
        drain();
        cfg_write(CFG_MEDIAN_OFFSET, offs);
        cfg_write(CFG_SILENCE_LEVEL, {9'd0, quiet});
        i_cfg_valid <= 1'b0;
        cur_offset = offs;
        settings_used++;
    endtask

    function automatic logic [15:0] random_time();
        case ($urandom_range(5, 0))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom_range(32'hFFFF, 0));
        endcase
    endfunction

    function automatic logic [15:0] time_above(input logic [15:0] thr);
        if (thr == 16'hFFFF) return thr;
        case ($urandom_range(7, 0))
            0, 1:    return thr + 16'd1;
            2:       return 16'hFFFF;
            default: return 16'($urandom_range(32'hFFFF, 32'(thr) + 1));
        endcase
    endfunction

    function automatic logic [15:0] time_at_most(input logic [15:0] thr);
        case ($urandom_range(7, 0))
            0, 1:    return thr;
            2:       return 16'h0000;
            default: return 16'($urandom_range(32'(thr), 0));
        endcase
    endfunction

    function automatic logic [7:0] pick_breath();
        int b;
        case ($urandom_range(9, 0))
            0:       b = $urandom_range(255, 0);
            1:       b = $urandom_range(base_plan, 0);
            2:       b = base_plan + 47;
            3:       b = base_plan + 46;
            default: b = base_plan + $urandom_range(70, 1);
        endcase
        return (b > 255) ? 8'hFF : 8'(b);
    endfunction

    function automatic t_times random_medians();
        t_times m;
        for (int ch = 0; ch < NUM_KEYS; ch++) m[ch] = random_time();
        return m;
    endfunction

    function automatic logic [7:0] random_rest();
        case ($urandom_range(7, 0))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(160, 0));
        endcase
    endfunction

    task automatic play_mask(input logic [5:0] mask, input logic [7:0] br);
        t_times t;
        for (int ch = 0; ch < NUM_KEYS; ch++) begin
            t[ch] = mask[ch] ? time_above(thr_plan[ch]) : time_at_most(thr_plan[ch]);
        end
        send_item(1'b1, t, br);
        prev_mask = mask;
    endtask

    task automatic play_random();
        t_times     t;
        logic [5:0] m;
        if (!thr_known) begin
            for (int ch = 0; ch < NUM_KEYS; ch++) t[ch] = random_time();
            send_item(1'b1, t, 8'($urandom_range(255, 0)));
        end else begin
            case ($urandom_range(5, 0))
                0, 1:    m = prev_mask;
                2:       m = 6'($urandom);
                default: m = FINGERINGS[$urandom_range(7, 0)*6 +: 6];
            endcase
            play_mask(m, pick_breath());
        end
    endtask

    // samples per key spread around a chosen median so the median is known
    task automatic cal_run_planned(input t_times med, input logic [7:0] rest, input bit mix);
        t_times      col [CAL_SAMPLES];
        logic [15:0] tmp;
        int          j;
        for (int ch = 0; ch < NUM_KEYS; ch++) begin
            col[0][ch] = med[ch];
            for (int k = 1; k < CAL_SAMPLES; k++) begin
                if (k <= CAL_SAMPLES/2) begin
                    col[k][ch] = time_at_most(med[ch]);
                end else begin
                    col[k][ch] = ($urandom_range(3, 0) == 0) ? med[ch] : time_above(med[ch]);
                end
            end
            for (int k = CAL_SAMPLES - 1; k > 0; k--) begin
                j          = $urandom_range(k, 0);
                tmp        = col[k][ch];
                col[k][ch] = col[j][ch];
                col[j][ch] = tmp;
            end
        end
        for (int s = 0; s < CAL_SAMPLES; s++) begin
            send_item(1'b0, col[s], (s == CAL_SAMPLES - 1) ? rest : 8'($urandom_range(255, 0)));
            // play frames in mid-run still see the previous thresholds
            if (mix && s < CAL_SAMPLES - 1 && $urandom_range(3, 0) == 0) play_random();
        end
        for (int ch = 0; ch < NUM_KEYS; ch++) thr_plan[ch] = med[ch] + cur_offset;
        base_plan = rest;
        thr_known = 1'b1;
        cal_runs++;
    endtask

    task automatic cal_run_noise();
        t_times t;
        repeat (CAL_SAMPLES) begin
            for (int ch = 0; ch < NUM_KEYS; ch++) t[ch] = random_time();
            send_item(1'b0, t, 8'($urandom_range(255, 0)));
        end
        thr_known = 1'b0;
        cal_runs++;
    endtask

    initial begin
        int waited;
        thr_plan      = '0;
        base_plan     = '0;
        thr_known     = 1'b1;
        prev_mask     = '0;
        settings_used = 1;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset thresholds and base are zero: silence, first note, repeat,
        // note change, unknown fingering, quiet but nonzero, back to sound
        send_item(1'b1, '0, 8'h00);
        send_item(1'b1, '1, 8'hFF);
        send_item(1'b1, '1, 8'hFF);
        play_mask(6'h1F, 8'd47);
        play_mask(6'h15, 8'd46);
        play_mask(6'h15, 8'd1);
        play_mask(6'h15, 8'd20);
        // medians at both extremes; key 1 threshold wraps past 16 bits
        cal_run_planned({16'hFF37, 16'd30000, 16'd1000, 16'd100, 16'hFFFF, 16'h0000},
                        8'd40, 1'b0);
        for (int i = 0; i < 8; i++) play_mask(FINGERINGS[i*6 +: 6], pick_breath());

        for (int p = 0; p < 5; p++) begin
            case (p)
                0:       new_setting(16'h0000, 7'd0);
                1:       new_setting(16'hFFFF, 7'd127);
                2:       new_setting(16'($urandom), 7'($urandom_range(126, 1)));
                3:       new_setting(16'd1, 7'd126);
                default: new_setting(16'd128, 7'd7);
            endcase
            cal_run_planned(random_medians(), random_rest(), 1'b1);
            repeat (18) begin
                play_random();
                if ($urandom_range(24, 0) == 0) drain();
            end
            if (p == 3) begin
                cal_run_noise();
                repeat (10) play_random();
                cal_run_planned(random_medians(), random_rest(), 1'b1);
                repeat (10) play_random();
            end
        end

        i_valid <= 1'b0;
        @(posedge i_clk);
        waited = 0;
        while (pending != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (FRAME_SETTLE) @(posedge i_clk);
        end_check <= 1'b1;
        @(posedge i_clk);
        end_check <= 1'b0;
        @(posedge i_clk);

        $display("Sent %0d calibration samples in %0d runs and %0d play frames, %0d settings.",
                 cal_items, cal_runs, play_items, settings_used);
        $display("Compared %0d MIDI bytes, %0d mismatches.", bytes_checked, fail_count);
        if (fail_count == 0) begin
            $display("tb_breath_touch_to_midi_encoder passed");
        end else begin
            $display("tb_breath_touch_to_midi_encoder failed");
        end
        $finish;
    end

endmodule
